// ===== rtl/jsu_pkg.sv =====
package jsu_pkg;

   // destination size limits
   localparam int MaxCapacity = 4096;
   localparam int CapWidth    = 13;
   localparam int CountWidth  = 12;
   localparam logic [CapWidth-1:0] CapReset = 13'd256;

   // decoder modes
   localparam logic [1:0] ModeNormal = 2'd0;
   localparam logic [1:0] ModeEsc    = 2'd1;
   localparam logic [1:0] ModeHex    = 2'd2;

   // characters of interest
   localparam logic [7:0] CharQuote  = 8'h22;
   localparam logic [7:0] CharBslash = 8'h5C;
   localparam logic [7:0] CharLowerU = 8'h75;
   localparam logic [7:0] CharLowerN = 8'h6E;
   localparam logic [7:0] CharLowerT = 8'h74;
   localparam logic [7:0] CharLowerR = 8'h72;
   localparam logic [7:0] CharLowerB = 8'h62;
   localparam logic [7:0] CharLowerF = 8'h66;
   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharNine   = 8'h39;
   localparam logic [7:0] CharLowerA = 8'h61;
   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperF = 8'h46;

   // control bytes produced by the short escapes
   localparam logic [7:0] CtlNewline  = 8'h0A;
   localparam logic [7:0] CtlTab      = 8'h09;
   localparam logic [7:0] CtlReturn   = 8'h0D;
   localparam logic [7:0] CtlBackspc  = 8'h08;
   localparam logic [7:0] CtlFormfeed = 8'h0C;

   // utf-8 encoding
   localparam logic [7:0]  Utf8Lead2  = 8'hC0;
   localparam logic [7:0]  Utf8Lead3  = 8'hE0;
   localparam logic [7:0]  Utf8Cont   = 8'h80;
   localparam logic [15:0] Utf8Limit1 = 16'h0080;
   localparam logic [15:0] Utf8Limit2 = 16'h0800;

   // pending continuation bytes
   localparam logic [1:0] PendNone = 2'd0;
   localparam logic [1:0] PendOne  = 2'd1;
   localparam logic [1:0] PendTwo  = 2'd2;

   typedef struct packed {
      logic [7:0] data;
      logic       is_quote;
      logic       is_bslash;
      logic       is_u;
      logic [7:0] esc_byte;
      logic [3:0] hex;
   } jsu_sym_type;

   typedef struct packed {
      jsu_sym_type sym;
      logic        last;
   } jsu_item_type;

   typedef struct packed {
      logic [7:0]            out_byte;
      logic                  has_byte;
      logic                  string_done;
      logic [CountWidth-1:0] out_count;
   } jsu_result_type;

   function automatic jsu_sym_type jsu_classify(input logic [7:0] c);
      jsu_sym_type s;
      s.data      = c;
      s.is_quote  = (c == CharQuote);
      s.is_bslash = (c == CharBslash);
      s.is_u      = (c == CharLowerU);
      case (c)
         CharLowerN: s.esc_byte = CtlNewline;
         CharLowerT: s.esc_byte = CtlTab;
         CharLowerR: s.esc_byte = CtlReturn;
         CharLowerB: s.esc_byte = CtlBackspc;
         CharLowerF: s.esc_byte = CtlFormfeed;
         default:    s.esc_byte = c;
      endcase
      if (c >= CharZero && c <= CharNine) begin
         s.hex = c[3:0];
      end else if ((c >= CharLowerA && c <= CharLowerF) ||
                   (c >= CharUpperA && c <= CharUpperF)) begin
         s.hex = c[3:0] + 4'd9;
      end else begin
         s.hex = 4'd0;
      end
      return s;
   endfunction

endpackage

// ===== rtl/jsu_stream_if.sv =====
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       region_end;

   modport source (output valid, output data_byte, output region_end, input ready);
   modport sink   (input valid, input data_byte, input region_end, output ready);
endinterface

interface jsu_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        has_byte;
   logic        string_done;
   logic [11:0] out_count;

   modport source (output valid, output out_byte, output has_byte, output string_done,
                   output out_count, input ready);
   modport sink   (input valid, input out_byte, input has_byte, input string_done,
                   input out_count, output ready);
endinterface

// ===== rtl/jsu_front.sv =====
module jsu_front
   import jsu_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   jsu_req_if.sink      req,
   output logic         head_valid,
   output jsu_item_type head,
   input  logic         pop
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);

   jsu_item_type          slot_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  push;

   assign req.ready  = (count_ff != CntWidth'(DEPTH));
   assign push       = req.valid && req.ready;
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // classify on the way in
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{sym: jsu_classify(req.data_byte), last: req.region_end};
      end
   end

endmodule

// ===== rtl/jsu_decode.sv =====
module jsu_decode
   import jsu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [CapWidth-1:0] cap,
   input  logic                head_valid,
   input  jsu_item_type        head,
   output logic                pop,
   input  logic                advance,
   output logic                push,
   output jsu_result_type      push_data
);

   logic [1:0]            mode_ff, mode_in;
   logic [1:0]            hs_ff, hs_in;
   logic [15:0]           cp_ff, cp_in;
   logic [7:0]            hexc_ff [4];
   logic [CountWidth-1:0] ec_ff, ec_in;
   logic                  fin_ff, fin_in;
   logic [1:0]            pend_ff, pend_in;
   logic [1:0]            rp_ptr_ff, rp_ptr_in;
   logic [1:0]            rp_rem_ff, rp_rem_in;
   logic                  rend_ff, rend_in;
   logic                  h_valid_ff, h_valid_in;
   logic                  h_final_ff, h_final_in;
   jsu_result_type        h_ff, h_in;

   logic                  src_pend, src_rp, src_new, ignore, act;
   jsu_sym_type           sym;
   logic                  last, step_rend;
   logic                  room_now, room_after;
   logic                  emit, item_done, hex_we;
   logic [7:0]            emit_byte;
   logic [15:0]           cp_new;
   logic [1:0]            mode_n, hs_n, pend_n, rp_ptr_n, rp_rem_n;
   logic [15:0]           cp_n;
   logic                  fin_n;
   logic [CountWidth-1:0] ec_n;
   logic                  step_end, endcond, dummy, new_res;
   jsu_result_type        res;

   // source priority: pending utf-8 bytes, then replayed hex chars, then a new item
   assign src_pend  = (pend_ff != PendNone);
   assign src_rp    = !src_pend && (rp_rem_ff != 2'd0);
   assign src_new   = !src_pend && !src_rp && head_valid;
   assign ignore    = src_new && fin_ff;
   assign act       = advance && (src_pend || src_rp || src_new);
   assign pop       = advance && src_new;

   assign sym       = src_rp ? jsu_classify(hexc_ff[rp_ptr_ff]) : head.sym;
   assign last      = src_rp ? (rend_ff && (rp_rem_ff == 2'd1)) : head.last;
   assign step_rend = src_new ? head.last : rend_ff;

   assign room_now   = ({1'b0, ec_ff} + CapWidth'(4)) < cap;
   assign room_after = ({1'b0, ec_ff} + CapWidth'(5)) < cap;
   assign cp_new     = {cp_ff[11:0], sym.hex};

   always_comb begin
      mode_n    = mode_ff;
      hs_n      = hs_ff;
      cp_n      = cp_ff;
      pend_n    = pend_ff;
      rp_ptr_n  = rp_ptr_ff;
      rp_rem_n  = rp_rem_ff;
      fin_n     = fin_ff;
      emit      = 1'b0;
      emit_byte = 8'd0;
      item_done = 1'b0;
      hex_we    = 1'b0;

      if (src_pend) begin
         emit = 1'b1;
         if (pend_ff == PendTwo) begin
            emit_byte = Utf8Cont | {2'b00, cp_ff[11:6]};
            pend_n    = PendOne;
         end else begin
            emit_byte = Utf8Cont | {2'b00, cp_ff[5:0]};
            pend_n    = PendNone;
            item_done = 1'b1;
         end
      end else if (src_rp || (src_new && !fin_ff)) begin
         if (src_rp) begin
            rp_ptr_n = rp_ptr_ff + 1'b1;
            rp_rem_n = rp_rem_ff - 1'b1;
         end
         case (mode_ff)
            ModeNormal: begin
               if (!room_now || sym.is_quote) begin
                  fin_n = 1'b1;
               end else if (sym.is_bslash) begin
                  mode_n = ModeEsc;
               end else begin
                  emit      = 1'b1;
                  emit_byte = sym.data;
                  item_done = 1'b1;
               end
            end
            ModeEsc: begin
               mode_n = ModeNormal;
               if (sym.is_u) begin
                  if (last) begin
                     emit      = 1'b1;
                     emit_byte = CharBslash;
                     item_done = 1'b1;
                  end else begin
                     mode_n = ModeHex;
                     hs_n   = 2'd0;
                     cp_n   = 16'd0;
                  end
               end else begin
                  emit      = 1'b1;
                  emit_byte = sym.esc_byte;
                  item_done = 1'b1;
               end
            end
            ModeHex: begin
               hex_we = 1'b1;
               cp_n   = cp_new;
               if (hs_ff == 2'd3) begin
                  mode_n = ModeNormal;
                  hs_n   = 2'd0;
                  emit   = 1'b1;
                  if (cp_new < Utf8Limit1) begin
                     emit_byte = cp_new[7:0];
                     item_done = 1'b1;
                  end else if (cp_new < Utf8Limit2) begin
                     emit_byte = Utf8Lead2 | {3'b000, cp_new[10:6]};
                     pend_n    = PendOne;
                  end else begin
                     emit_byte = Utf8Lead3 | {4'b0000, cp_new[15:12]};
                     pend_n    = PendTwo;
                  end
               end else if (last) begin
                  // short escape at region end: backslash, then decode the gathered chars again
                  mode_n    = ModeNormal;
                  emit      = 1'b1;
                  emit_byte = CharBslash;
                  item_done = 1'b1;
                  rp_ptr_n  = 2'd0;
                  rp_rem_n  = hs_ff + 1'b1;
                  hs_n      = 2'd0;
               end else begin
                  hs_n = hs_ff + 1'b1;
               end
            end
            default: begin
               mode_n = ModeNormal;
            end
         endcase
      end

      if (item_done && !room_after) begin
         fin_n = 1'b1;
      end
      if (fin_n) begin
         rp_rem_n = 2'd0;
      end
   end

   assign ec_n     = emit ? ec_ff + 1'b1 : ec_ff;
   assign step_end = act && !ignore && (pend_n == PendNone) && (rp_rem_n == 2'd0);
   assign endcond  = fin_n || step_rend;
   // a step that ends the string with nothing emitted gives one result, unless an open held result takes string_done
   assign dummy    = step_end && endcond && !emit && !(h_valid_ff && !h_final_ff);
   assign new_res  = act && (emit || dummy);

   assign res.out_byte    = emit ? emit_byte : 8'd0;
   assign res.has_byte    = emit;
   assign res.string_done = endcond;
   assign res.out_count   = ec_n;

   // hold stage: a result leaves once it is known whether it closes the step
   assign push = advance && h_valid_ff && (h_final_ff || new_res || step_end);
   always_comb begin
      push_data = h_ff;
      push_data.string_done = h_final_ff ? h_ff.string_done : (step_end && !new_res && endcond);
   end

   always_comb begin
      mode_in    = mode_ff;
      hs_in      = hs_ff;
      cp_in      = cp_ff;
      ec_in      = ec_ff;
      fin_in     = fin_ff;
      pend_in    = pend_ff;
      rp_ptr_in  = rp_ptr_ff;
      rp_rem_in  = rp_rem_ff;
      rend_in    = rend_ff;
      h_valid_in = h_valid_ff;
      h_final_in = h_final_ff;
      h_in       = h_ff;

      if (act) begin
         if (src_new) begin
            rend_in = head.last;
         end
         if (!ignore) begin
            mode_in   = mode_n;
            hs_in     = hs_n;
            cp_in     = cp_n;
            ec_in     = ec_n;
            fin_in    = fin_n;
            pend_in   = pend_n;
            rp_ptr_in = rp_ptr_n;
            rp_rem_in = rp_rem_n;
            if (step_end && endcond) begin
               fin_in = 1'b1;
            end
         end
         // region end re-arms for the next string
         if ((ignore || step_end) && step_rend) begin
            mode_in = ModeNormal;
            hs_in   = 2'd0;
            cp_in   = 16'd0;
            ec_in   = '0;
            fin_in  = 1'b0;
         end
      end

      if (new_res) begin
         h_valid_in = 1'b1;
         h_final_in = step_end;
         h_in       = res;
      end else if (push) begin
         h_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= ModeNormal;
         hs_ff      <= 2'd0;
         cp_ff      <= 16'd0;
         ec_ff      <= '0;
         fin_ff     <= 1'b0;
         pend_ff    <= PendNone;
         rp_ptr_ff  <= 2'd0;
         rp_rem_ff  <= 2'd0;
         rend_ff    <= 1'b0;
         h_valid_ff <= 1'b0;
         h_final_ff <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         hs_ff      <= hs_in;
         cp_ff      <= cp_in;
         ec_ff      <= ec_in;
         fin_ff     <= fin_in;
         pend_ff    <= pend_in;
         rp_ptr_ff  <= rp_ptr_in;
         rp_rem_ff  <= rp_rem_in;
         rend_ff    <= rend_in;
         h_valid_ff <= h_valid_in;
         h_final_ff <= h_final_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff <= h_in;
      if (act && hex_we) begin
         hexc_ff[hs_ff] <= sym.data;
      end
   end

endmodule

// ===== rtl/json_string_unescape_core.sv =====
// json string unescaper: feed it the bytes of a json string value that follow the opening
// quote, one request per byte, with region_end on the last byte of the region; it returns
// the unescaped bytes with a running count, and string_done on the last response of each
// string (a response without a byte when the string closes on a quote, a full buffer or a
// dropped trailing backslash). \n \t \r \b \f become control bytes, other escaped bytes stand
// for themselves, and \uXXXX becomes one to three utf-8 bytes. a steady stream of plain bytes
// runs at one request and one response per cycle while the response side is ready; a \u
// escape that needs two or three utf-8 bytes holds the decoder while its continuation bytes
// go out, and a \u cut short at region end holds it while the gathered hex characters (up to
// three, which may hold a further \u that is cut short in turn) are decoded again. the
// decoder emits at most one response a cycle while the output register can take it. requests
// pass through a small queue, the decoder and a hold stage before the output register.
// csr_wr_data sets the buffer capacity (values above 4096 act as 4096); the user must write
// it only while the block is idle, and the block itself does not enforce this.
module json_string_unescape_core
   import jsu_pkg::*;
#(
   parameter int FIFO_DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   jsu_req_if.sink             req_stream,
   jsu_rsp_if.source           rsp_stream,
   input  logic                csr_wr_en,
   input  logic [CapWidth-1:0] csr_wr_data
);

   // capacity register, clamped on write
   logic [CapWidth-1:0] cap_ff, cap_in;

   // queue head between front and decoder
   logic                head_valid;
   jsu_item_type        head;
   logic                pop;

   // decoder to output register
   logic                advance;
   logic                push;
   jsu_result_type      push_data;

   // output register
   logic                o_valid_ff, o_valid_in;
   jsu_result_type      o_ff, o_in;

   assign cap_in = !csr_wr_en ? cap_ff :
                   (csr_wr_data > CapWidth'(MaxCapacity)) ? CapWidth'(MaxCapacity) :
                   csr_wr_data;

   // front end: takes requests and classifies them into the queue
   jsu_front #(
      .DEPTH (FIFO_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_stream),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   // back end: decodes one step a cycle while the output register can take a response
   assign advance = !o_valid_ff || rsp_stream.ready;

   jsu_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .cap        (cap_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .advance    (advance),
      .push       (push),
      .push_data  (push_data)
   );

   always_comb begin
      o_valid_in = o_valid_ff;
      o_in       = o_ff;
      if (push) begin
         o_valid_in = 1'b1;
         o_in       = push_data;
      end else if (rsp_stream.ready) begin
         o_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= CapReset;
         o_valid_ff <= 1'b0;
      end else begin
         cap_ff     <= cap_in;
         o_valid_ff <= o_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      o_ff <= o_in;
   end

   assign rsp_stream.valid       = o_valid_ff;
   assign rsp_stream.out_byte    = o_ff.out_byte;
   assign rsp_stream.has_byte    = o_ff.has_byte;
   assign rsp_stream.string_done = o_ff.string_done;
   assign rsp_stream.out_count   = o_ff.out_count;

endmodule

// ===== rtl/jsu_checker.sv =====
module jsu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_has_byte,
   input logic        rsp_string_done,
   input logic [11:0] rsp_out_count
);

   logic rsp_fire;

   assign rsp_fire = rsp_valid && rsp_ready;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_has_byte) && $stable(rsp_string_done) && $stable(rsp_out_count))
      else $error("response changed while stalled");

   // a response without a byte only closes a string
   a_empty_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_byte |-> rsp_string_done && (rsp_out_byte == 8'd0))
      else $error("empty response not closing a string");

   // count steps by one within a string
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_has_byte && !rsp_string_done) ##1 (rsp_fire && rsp_has_byte) |->
      rsp_out_count == 12'($past(rsp_out_count) + 12'd1))
      else $error("byte count skipped");

   // a new string starts counting at one
   a_count_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_string_done) ##1 (rsp_fire && rsp_has_byte) |->
      rsp_out_count == 12'd1)
      else $error("byte count not restarted");

endmodule

bind json_string_unescape_core jsu_checker u_jsu_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_stream.valid),
   .rsp_ready       (rsp_stream.ready),
   .rsp_out_byte    (rsp_stream.out_byte),
   .rsp_has_byte    (rsp_stream.has_byte),
   .rsp_string_done (rsp_stream.string_done),
   .rsp_out_count   (rsp_stream.out_count)
);

// ===== dv/jsu_unescape_monitor.sv =====
module jsu_unescape_monitor
   import jsu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   jsu_req_if                  req_mon,
   jsu_rsp_if                  rsp_mon,
   input  logic                csr_wr_en,
   input  logic [CapWidth-1:0] csr_wr_data,
   output int                  mismatch_count,
   output int                  expected_left
);

   localparam int MaxStepResults = 5;
   localparam int ReplayDepth    = 12;

   logic [CapWidth-1:0]   capacity;
   logic [1:0]            mode;
   logic [2:0]            hex_cnt;
   logic [15:0]           code_pt;
   logic [7:0]            hex_buf [4];
   logic [CountWidth-1:0] byte_cnt;
   logic                  stopped;
   logic                  replay;
   jsu_result_type        step_res [$];
   jsu_result_type        decoded_q [$];

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c >= CharZero && c <= CharNine) begin
         v = c - CharZero;
      end else if (c >= CharLowerA && c <= CharLowerF) begin
         v = c - CharLowerA + 8'd10;
      end else if (c >= CharUpperA && c <= CharUpperF) begin
         v = c - CharUpperA + 8'd10;
      end
      return v[3:0];
   endfunction

   function automatic bit has_room();
      int cap_eff;
      cap_eff = (int'(capacity) > MaxCapacity) ? MaxCapacity : int'(capacity);
      return int'(byte_cnt) + 4 < cap_eff;
   endfunction

   function automatic void add_result(input logic [7:0] b, input logic has);
      jsu_result_type r;
      if (step_res.size() >= MaxStepResults) return;
      r.out_byte    = b;
      r.has_byte    = has;
      r.string_done = 1'b0;
      r.out_count   = byte_cnt;
      step_res.push_back(r);
   endfunction

   function automatic void put_byte(input logic [7:0] b);
      byte_cnt = byte_cnt + 1'b1;
      add_result(b, 1'b1);
   endfunction

   function automatic void check_full();
      if (!has_room()) stopped = 1'b1;
   endfunction

   function automatic void restart();
      mode     = ModeNormal;
      hex_cnt  = '0;
      code_pt  = '0;
      byte_cnt = '0;
      stopped  = 1'b0;
   endfunction

   function automatic void decode_char(input logic [7:0] c, input bit last);
      case (mode)
         ModeNormal: begin
            if (!has_room() || c == CharQuote) begin
               stopped = 1'b1;
            end else if (c == CharBslash) begin
               mode = ModeEsc;
            end else begin
               put_byte(c);
               check_full();
            end
         end
         ModeEsc: begin
            mode = ModeNormal;
            case (c)
               CharLowerN: put_byte(CtlNewline);
               CharLowerT: put_byte(CtlTab);
               CharLowerR: put_byte(CtlReturn);
               CharLowerB: put_byte(CtlBackspc);
               CharLowerF: put_byte(CtlFormfeed);
               CharLowerU: begin
                  if (last) begin
                     put_byte(CharBslash);
                  end else begin
                     mode    = ModeHex;
                     hex_cnt = '0;
                     code_pt = '0;
                  end
               end
               default: put_byte(c);
            endcase
            if (mode == ModeNormal) check_full();
         end
         default: begin
            hex_buf[hex_cnt[1:0]] = c;
            code_pt = {code_pt[11:0], hex_nibble(c)};
            hex_cnt = hex_cnt + 1'b1;
            if (hex_cnt >= 3'd4) begin
               mode    = ModeNormal;
               hex_cnt = '0;
               if (code_pt < Utf8Limit1) begin
                  put_byte(code_pt[7:0]);
               end else if (code_pt < Utf8Limit2) begin
                  put_byte(Utf8Lead2 | {3'b000, code_pt[10:6]});
                  put_byte(Utf8Cont | {2'b00, code_pt[5:0]});
               end else begin
                  put_byte(Utf8Lead3 | {4'b0000, code_pt[15:12]});
                  put_byte(Utf8Cont | {2'b00, code_pt[11:6]});
                  put_byte(Utf8Cont | {2'b00, code_pt[5:0]});
               end
               check_full();
            end else if (last) begin
               // short hex escape: backslash out, gathered chars go round again
               mode = ModeNormal;
               put_byte(CharBslash);
               check_full();
               replay = 1'b1;
            end
         end
      endcase
   endfunction

   function automatic void unescape_request(input logic [7:0] c, input logic rend);
      logic [7:0]     pend [$];
      jsu_result_type r;
      int             i;
      step_res.delete();
      if (stopped) begin
         if (rend) restart();
         return;
      end
      pend.push_back(c);
      i = 0;
      while (i < pend.size() && !stopped) begin
         replay = 1'b0;
         decode_char(pend[i], rend && (i == pend.size() - 1));
         if (replay) begin
            for (int k = 0; k < int'(hex_cnt[1:0]) && pend.size() < ReplayDepth; k++) begin
               pend.push_back(hex_buf[k]);
            end
            hex_cnt = '0;
         end
         i++;
      end
      if (stopped || rend) begin
         if (step_res.size() == 0) add_result(8'h00, 1'b0);
         r = step_res[step_res.size() - 1];
         r.string_done = 1'b1;
         step_res[step_res.size() - 1] = r;
         stopped = 1'b1;
      end
      if (rend) restart();
      foreach (step_res[j]) decoded_q.push_back(step_res[j]);
   endfunction

   function automatic void report_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
      mismatch_count++;
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
   endfunction

   function automatic void check_result(input logic [7:0] b, input logic has,
                                        input logic done, input logic [CountWidth-1:0] cnt);
      jsu_result_type want;
      if (decoded_q.size() == 0) begin
         mismatch_count++;
         $error("unexpected response: out_byte %0h has_byte %0b string_done %0b out_count %0d",
                b, has, done, cnt);
         return;
      end
      want = decoded_q.pop_front();
      if (b !== want.out_byte) report_field("out_byte", want.out_byte, b);
      if (has !== want.has_byte) report_field("has_byte", want.has_byte, has);
      if (done !== want.string_done) report_field("string_done", want.string_done, done);
      if (cnt !== want.out_count) report_field("out_count", want.out_count, cnt);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         capacity = CapReset;
         restart();
         hex_buf        = '{default: 8'h00};
         mismatch_count = 0;
         decoded_q.delete();
      end else begin
         if (csr_wr_en) capacity = csr_wr_data;
         if (req_mon.valid && req_mon.ready) begin
            unescape_request(req_mon.data_byte, req_mon.region_end);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_result(rsp_mon.out_byte, rsp_mon.has_byte, rsp_mon.string_done,
                         rsp_mon.out_count);
         end
      end
      expected_left = decoded_q.size();
   end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
   import jsu_pkg::*;

   // timing of the bench
   localparam int ClockHalf   = 6;
   localparam int ResetCycles = 6;
   localparam int DrainCycles = 16;      // pipeline depth plus re-decoded hex chars
   localparam int HoldCycles  = 80;      // long response hold-off, fills the request queue
   localparam int CycleLimit  = 400000;
   localparam int PhaseBytes  = 9;
   localparam int NumPhases   = 8;

   // response side stall behaviour
   typedef enum int {RxFree, RxCoinFlip, RxEveryFourth, RxRareStall} rx_mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } req_byte_type;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [CapWidth-1:0] csr_wr_data;
   int                  mismatch_count;
   int                  expected_left;
   int                  cycle_count;
   int                  hold_requests;
   int                  burst_left;
   int                  gap_max;
   req_byte_type        stim_q [$];

   // capacity per phase; zero picks a small random size that strings can overrun
   int phase_cap [NumPhases] = '{1, 5, 8191, 4096, 0, 0, 0, 256};

   jsu_req_if req_if ();
   jsu_rsp_if rsp_if ();

   json_string_unescape_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_stream  (req_if),
      .rsp_stream  (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // watches both channels and the capacity writes, predicts and compares
   jsu_unescape_monitor i_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .expected_left  (expected_left)
   );

   initial begin
      clock = 1'b0;
      forever #ClockHalf clock = ~clock;
   end

   // hard stop if the run hangs
   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL json_string_unescape_core");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------------------------------

   function automatic void add_byte(input logic [7:0] b, input logic close);
      req_byte_type it;
      it.data = b;
      it.last = close;
      stim_q.push_back(it);
   endfunction

   // a literal string, region end on its final byte when close is set
   function automatic void add_text(input string s, input logic close);
      for (int k = 0; k < s.len(); k++) add_byte(s[k], close && (k == s.len() - 1));
   endfunction

   function automatic logic [7:0] any_byte();
      logic [7:0] v;
      v = 8'($urandom_range(0, 255));
      return v;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return CharZero + {4'd0, n};
      if ($urandom_range(0, 1) == 0) return CharLowerA + {4'd0, n} - 8'd10;
      return CharUpperA + {4'd0, n} - 8'd10;
   endfunction

   // character after a backslash: the control escapes, the literal ones, or anything
   function automatic logic [7:0] esc_char();
      case ($urandom_range(0, 8))
         0:       return CharLowerN;
         1:       return CharLowerT;
         2:       return CharLowerR;
         3:       return CharLowerB;
         4:       return CharLowerF;
         5:       return CharQuote;
         6:       return CharBslash;
         7:       return 8'h2F;
         default: return any_byte();
      endcase
   endfunction

   // one string: mostly well formed content, then one of several ways to close it
   function automatic void add_string();
      int          pieces;
      int          kind;
      int          n;
      logic [15:0] cp;
      logic [7:0]  b;
      pieces = $urandom_range(0, 12);
      for (int k = 0; k < pieces; k++) begin
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            // plain byte, kept clear of quote and backslash
            b = any_byte();
            if (b == CharQuote || b == CharBslash) b = 8'h41;
            add_byte(b, 1'b0);
         end else if (kind < 62) begin
            add_byte(CharBslash, 1'b0);
            add_byte(esc_char(), 1'b0);
         end else if (kind < 90) begin
            // \u with a code point from each utf-8 length class, now and then a bad digit
            case ($urandom_range(0, 2))
               0:       cp = 16'($urandom_range(0, 16'h007F));
               1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
               default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            endcase
            add_byte(CharBslash, 1'b0);
            add_byte(CharLowerU, 1'b0);
            for (int j = 0; j < 4; j++) begin
               b = ($urandom_range(0, 11) == 0) ? any_byte() : hex_char(cp[4*(3-j) +: 4]);
               add_byte(b, 1'b0);
            end
         end else begin
            add_byte(any_byte(), 1'b0);
         end
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            // closing quote, then junk up to the region end
            n = $urandom_range(0, 3);
            add_byte(CharQuote, n == 0);
            for (int k = 0; k < n; k++) begin
               b = ($urandom_range(0, 3) == 0) ? CharBslash : any_byte();
               add_byte(b, k == n - 1);
            end
         end
         5: add_byte(any_byte(), 1'b1);
         6: add_byte(CharBslash, 1'b1);
         7: begin
            // \u cut short by the region end, digits may be quote, backslash or u
            n = $urandom_range(0, 3);
            add_byte(CharBslash, 1'b0);
            add_byte(CharLowerU, n == 0);
            for (int k = 0; k < n; k++) begin
               case ($urandom_range(0, 5))
                  0:       b = CharQuote;
                  1:       b = CharBslash;
                  2:       b = CharLowerU;
                  default: b = hex_char(4'($urandom_range(0, 15)));
               endcase
               add_byte(b, k == n - 1);
            end
         end
         8: begin
            // noise with region ends scattered through it
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++) begin
               add_byte(any_byte(), (k == n - 1) || ($urandom_range(0, 5) == 0));
            end
         end
         default: begin
            add_byte(CharBslash, 1'b0);
            add_byte(esc_char(), 1'b1);
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // request driver: bursts of random length, random gaps when gap_max allows
   // ---------------------------------------------------------------------------------------

   task automatic push_req(input logic [7:0] b, input logic close);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_if.valid      = 1'b1;
      req_if.data_byte  = b;
      req_if.region_end = close;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_queued();
      req_byte_type it;
      while (stim_q.size() != 0) begin
         it = stim_q.pop_front();
         push_req(it.data, it.last);
      end
      req_if.valid = 1'b0;
   endtask

   // all responses in, then a wait of DrainCycles for requests that give none
   task automatic wait_drained();
      while (expected_left != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CapWidth-1:0] v);
      csr_wr_en   = 1'b1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   // ---------------------------------------------------------------------------------------
   // response side: stall pattern of its own, plus a long hold-off on request
   // ---------------------------------------------------------------------------------------

   initial begin
      int          hold_left;
      int          holds_taken;
      int          mode_left;
      int          tick;
      rx_mode_type rx_mode;
      hold_left     = 0;
      holds_taken   = 0;
      mode_left     = 0;
      tick          = 0;
      rx_mode       = RxFree;
      rsp_if.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_if.ready = 1'b0;
            hold_left--;
         end else if (holds_taken != hold_requests) begin
            holds_taken++;
            hold_left    = HoldCycles - 1;
            rsp_if.ready = 1'b0;
         end else begin
            if (mode_left == 0) begin
               rx_mode   = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(8, 64);
            end
            mode_left--;
            tick++;
            case (rx_mode)
               RxFree:        rsp_if.ready = 1'b1;
               RxCoinFlip:    rsp_if.ready = 1'($urandom_range(0, 1));
               RxEveryFourth: rsp_if.ready = (tick % 4 == 0);
               default:       rsp_if.ready = ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      int cap;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_if.valid      = 1'b0;
      req_if.data_byte  = '0;
      req_if.region_end = 1'b0;
      hold_requests     = 0;
      burst_left        = 0;
      gap_max           = 4;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed, at the reset capacity: the control escapes and \\, each utf-8 length with a surrogate,
      // raw zero and ff, quote with junk behind it, a dropped trailing backslash and a
      // short \u whose digits are decoded again as plain bytes
      add_text("\\n\\t\\r\\b\\f\\\\\\u0041\\u00e9\\uD800", 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(CharQuote, 1'b0);
      add_byte(8'h78, 1'b1);
      add_byte(CharBslash, 1'b1);
      add_text("\\u41", 1'b1);
      send_queued();
      wait_drained();

      // random phases, capacity rewritten only while the block is idle
      for (int p = 0; p < NumPhases; p++) begin
         cap = (phase_cap[p] == 0) ? $urandom_range(6, 40) : phase_cap[p];
         write_capacity(CapWidth'(cap));
         gap_max = (p % 3 == 1) ? 0 : $urandom_range(2, 8);
         while (stim_q.size() < PhaseBytes) add_string();
         if (phase_cap[p] == 8191) begin
            // eager sender against a long response hold-off
            gap_max = 0;
            hold_requests = hold_requests + 1;
         end
         send_queued();
         wait_drained();
      end

      if (mismatch_count == 0 && expected_left == 0) begin
         $display("PASS json_string_unescape_core");
      end else begin
         $display("FAIL json_string_unescape_core");
      end
      $finish;
   end

endmodule
